// ===== rtl/fpss_pkg.sv =====
// Shared constants, types and functions for the fixed-point sigmoid / SiLU core.
// Holds the exp(-n) table, the divider step and the datapath widths.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fpss_pkg;

	localparam int X_W       = 32;
	localparam int FRAC_BITS = 12;
	localparam int ONE_SCALE = 4096;
	localparam int SIG_W     = 13;
	localparam int F_W       = FRAC_BITS;
	localparam int Q_W       = X_W - FRAC_BITS;
	localparam int R_W       = FRAC_BITS + 1;
	localparam int E_W       = 13;
	localparam int DIFF_W    = 12;
	localparam int PROD_W    = DIFF_W + F_W;
	localparam int D_W       = 14;
	localparam int N_W       = 25;
	localparam int REM_W     = D_W - 1;
	localparam int DIV_BITS  = 13;
	localparam int DIV_STEPS = 3;
	localparam int DIV_STAGES = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;
	localparam int RS_W      = 26;

	localparam logic [D_W-1:0] ONE_D   = D_W'(ONE_SCALE);
	localparam logic [N_W-1:0] ONE_SQ  = N_W'(ONE_SCALE * ONE_SCALE);
	localparam logic signed [RS_W-1:0] HALF_RS = RS_W'(ONE_SCALE / 2);

	typedef struct packed {
		logic [REM_W-1:0]    rem;
		logic [DIV_BITS-1:0] nlo;
		logic [DIV_BITS-1:0] quo;
	} div_t;

	function automatic logic [E_W-1:0] exp_rom_at(input logic [3:0] idx);
		logic [E_W-1:0] v;
		case (idx)
			4'd0: v = 13'd4096;
			4'd1: v = 13'd1507;
			4'd2: v = 13'd554;
			4'd3: v = 13'd204;
			4'd4: v = 13'd75;
			4'd5: v = 13'd28;
			4'd6: v = 13'd10;
			4'd7: v = 13'd4;
			4'd8: v = 13'd1;
			default: v = 13'd0;
		endcase
		return v;
	endfunction

	function automatic div_t div_step(input div_t st, input logic [D_W-1:0] den);
		logic [D_W-1:0] t;
		div_t nx;
		t = {st.rem, st.nlo[DIV_BITS-1]};
		nx.nlo = {st.nlo[DIV_BITS-2:0], 1'b0};
		if (t >= den) begin
			nx.rem = REM_W'(t - den);
			nx.quo = {st.quo[DIV_BITS-2:0], 1'b1};
		end else begin
			nx.rem = t[REM_W-1:0];
			nx.quo = {st.quo[DIV_BITS-2:0], 1'b0};
		end
		return nx;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/fixed_point_sigmoid_silu_core.sv =====
// Top level of the fixed-point sigmoid / SiLU core: table lookup, interpolation,
// pipelined restoring divider and SiLU product stages.
// Depends on fpss_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Input channel x_valid / x_stall carries one signed Q19.12 value per beat
//   on x_value. Output channel result_valid / result_stall carries one beat
//   per input beat with sigmoid_value (0..4096, 4096 = 1.0) and silu_value
//   (x times sigmoid, 12 fraction bits). A beat moves on a rising edge with
//   valid high and stall low.
//   From input beat to result_valid the pipeline has one stage for the exp
//   table lookup, one for the interpolation multiply, one to form the divider
//   operands, five for the 13-bit restoring divider at up to three quotient
//   bits per stage, and two for the SiLU multiply and rounding.
//   Throughput is one beat per cycle while the receiver does not stall; every
//   stage is a register with its own valid bit.
//   When the receiver stalls, the result register holds and the stages behind
//   it keep filling empty slots; x_stall rises once no slot is free.
//   Asynchronous reset clears all valid bits; the pipeline is empty and ready
//   once reset is released.
module fixed_point_sigmoid_silu_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          x_valid,
	output logic                               x_stall,
	input  wire logic signed [fpss_pkg::X_W-1:0] x_value,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [fpss_pkg::SIG_W-1:0]         sigmoid_value,
	output logic signed [fpss_pkg::X_W-1:0]    silu_value
);
	import fpss_pkg::*;

	logic              neg_c, big_c;
	logic [X_W-1:0]    mag_c;
	logic [2:0]        n_c;
	logic [E_W-1:0]    lo_c, hi_c;
	logic [Q_W-1:0]    q_c;
	logic [R_W-1:0]    r_c;

	logic              vld_s1, en_s1;
	logic              neg_s1, big_s1;
	logic [E_W-1:0]    lo_s1;
	logic [DIFF_W-1:0] diff_s1;
	logic [F_W-1:0]    f_s1;
	logic [Q_W-1:0]    q_s1;
	logic [R_W-1:0]    r_s1;

	logic              vld_s2, en_s2;
	logic              neg_s2, big_s2;
	logic [E_W-1:0]    lo_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [Q_W-1:0]    q_s2;
	logic [R_W-1:0]    r_s2;

	logic [E_W-1:0]    e_c;
	logic [D_W-1:0]    d_c;
	logic [N_W-1:0]    num_c;

	div_t              div_s  [0:DIV_STAGES];
	div_t              div_nx [1:DIV_STAGES];
	logic [D_W-1:0]    den_s  [0:DIV_STAGES-1];
	logic [Q_W-1:0]    qd_s   [0:DIV_STAGES];
	logic [R_W-1:0]    rd_s   [0:DIV_STAGES];
	logic              vld_div_s [0:DIV_STAGES];
	logic              en_div    [0:DIV_STAGES];

	logic              vld_s9, en_s9;
	logic signed [Q_W+SIG_W:0]   qs_full;
	logic signed [R_W+SIG_W:0]   rs_full;
	logic signed [X_W-1:0]       qs_s9;
	logic signed [RS_W-1:0]      rs_s9;
	logic [SIG_W-1:0]            sig_s9;

	logic              vld_s10, en_s10;
	logic signed [RS_W-1:0]      rv_c;
	logic [RS_W-1:0]             rm_c;
	logic [RS_W-FRAC_BITS-1:0]   tm_c;
	logic [SIG_W-1:0]            sig_s10;
	logic signed [X_W-1:0]       silu_s10;

	// ready chain, back to front
	always_comb begin
		en_s10 = !vld_s10 || !result_stall;
		en_s9  = !vld_s9 || en_s10;
		en_div[DIV_STAGES] = !vld_div_s[DIV_STAGES] || en_s9;
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			en_div[k] = !vld_div_s[k] || en_div[k+1];
		end
		en_s2 = !vld_s2 || en_div[0];
		en_s1 = !vld_s1 || en_s2;
	end

	assign x_stall = !en_s1;

	// stage 1: magnitude, table lookup, truncating split into q and r
	always_comb begin
		neg_c = x_value[X_W-1];
		mag_c = neg_c ? (X_W'(0) - x_value) : x_value;
		big_c = |mag_c[X_W-1:FRAC_BITS+3];
		n_c   = mag_c[FRAC_BITS+2:FRAC_BITS];
		lo_c  = exp_rom_at({1'b0, n_c});
		hi_c  = exp_rom_at({1'b0, n_c} + 4'd1);
		q_c   = neg_c ? (Q_W'(0) - mag_c[X_W-1:FRAC_BITS]) : mag_c[X_W-1:FRAC_BITS];
		r_c   = neg_c ? (R_W'(0) - {1'b0, mag_c[FRAC_BITS-1:0]})
		              : {1'b0, mag_c[FRAC_BITS-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= x_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			neg_s1  <= neg_c;
			big_s1  <= big_c;
			lo_s1   <= lo_c;
			diff_s1 <= DIFF_W'(lo_c - hi_c);
			f_s1    <= mag_c[FRAC_BITS-1:0];
			q_s1    <= q_c;
			r_s1    <= r_c;
		end
	end

	// stage 2: interpolation product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			neg_s2  <= neg_s1;
			big_s2  <= big_s1;
			lo_s2   <= lo_s1;
			prod_s2 <= {{F_W{1'b0}}, diff_s1} * {{DIFF_W{1'b0}}, f_s1};
			q_s2    <= q_s1;
			r_s2    <= r_s1;
		end
	end

	// stage 3: exp value, divisor and rounded numerator
	always_comb begin
		e_c   = big_s2 ? '0 : E_W'(lo_s2 - {1'b0, prod_s2[PROD_W-1:FRAC_BITS]});
		d_c   = ONE_D + {1'b0, e_c};
		num_c = (neg_s2 ? {e_c, {FRAC_BITS{1'b0}}} : ONE_SQ) + N_W'(d_c >> 1);
	end

	// divider stages: up to three quotient bits each
	always_comb begin
		for (int k = 1; k <= DIV_STAGES; k++) begin
			div_nx[k] = div_s[k-1];
			for (int j = 0; j < DIV_STEPS; j++) begin
				if (((k - 1) * DIV_STEPS + j) < DIV_BITS) begin
					div_nx[k] = div_step(div_nx[k], den_s[k-1]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STAGES; k++) begin
				vld_div_s[k] <= 1'b0;
			end
		end else begin
			if (en_div[0]) begin
				vld_div_s[0] <= vld_s2;
			end
			for (int k = 1; k <= DIV_STAGES; k++) begin
				if (en_div[k]) begin
					vld_div_s[k] <= vld_div_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_div[0]) begin
			div_s[0].rem <= {1'b0, num_c[N_W-1:DIV_BITS]};
			div_s[0].nlo <= num_c[DIV_BITS-1:0];
			div_s[0].quo <= '0;
			den_s[0]     <= d_c;
			qd_s[0]      <= q_s2;
			rd_s[0]      <= r_s2;
		end
		for (int k = 1; k <= DIV_STAGES; k++) begin
			if (en_div[k]) begin
				div_s[k] <= div_nx[k];
				qd_s[k]  <= qd_s[k-1];
				rd_s[k]  <= rd_s[k-1];
			end
		end
		for (int k = 1; k < DIV_STAGES; k++) begin
			if (en_div[k]) begin
				den_s[k] <= den_s[k-1];
			end
		end
	end

	// stage 9: SiLU partial products
	always_comb begin
		qs_full = $signed(qd_s[DIV_STAGES]) * $signed({1'b0, div_s[DIV_STAGES].quo});
		rs_full = $signed(rd_s[DIV_STAGES]) * $signed({1'b0, div_s[DIV_STAGES].quo});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en_s9) begin
			vld_s9 <= vld_div_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s9) begin
			qs_s9  <= qs_full[X_W-1:0];
			rs_s9  <= rs_full[RS_W-1:0];
			sig_s9 <= div_s[DIV_STAGES].quo;
		end
	end

	// stage 10: add half to the fraction product, truncate toward zero and sum
	always_comb begin
		rv_c = rs_s9 + HALF_RS;
		rm_c = rv_c[RS_W-1] ? (RS_W'(0) - rv_c) : rv_c;
		tm_c = rm_c[RS_W-1:FRAC_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en_s10) begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s10) begin
			sig_s10  <= sig_s9;
			silu_s10 <= rv_c[RS_W-1] ? (qs_s9 - X_W'(tm_c)) : (qs_s9 + X_W'(tm_c));
		end
	end

	assign result_valid  = vld_s10;
	assign sigmoid_value = sig_s10;
	assign silu_value    = silu_s10;

endmodule

`default_nettype wire

// ===== rtl/fpss_checker.sv =====
// Port-level checks for the fixed-point sigmoid / SiLU core, bound to the top level.
// Depends on fpss_pkg and fixed_point_sigmoid_silu_core.
`timescale 1ns / 1ps
`default_nettype none

module fpss_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            x_valid,
	input wire logic                            x_stall,
	input wire logic signed [fpss_pkg::X_W-1:0] x_value,
	input wire logic                            result_valid,
	input wire logic                            result_stall,
	input wire logic [fpss_pkg::SIG_W-1:0]      sigmoid_value,
	input wire logic signed [fpss_pkg::X_W-1:0] silu_value
);
	import fpss_pkg::*;

	logic unused_in;
	assign unused_in = x_valid ^ (^x_value);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(sigmoid_value) && $stable(silu_value))
		else $error("stalled result changed");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !x_stall)
		else $error("input stalled with empty output");

	a_sig_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> sigmoid_value <= SIG_W'(ONE_SCALE))
		else $error("sigmoid out of range");

	a_zero_silu: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && sigmoid_value == '0 |-> silu_value == '0)
		else $error("nonzero silu with zero sigmoid");

endmodule

bind fixed_point_sigmoid_silu_core fpss_checker u_fpss_checker (.*);

`default_nettype wire

// ===== tb/tb_fixed_point_sigmoid_silu_core.sv =====
// Self-checking testbench for fixed_point_sigmoid_silu_core: drives directed and random
// fixed-point arguments with random bursts and stalls, and checks sigmoid and SiLU beats.
// Depends on fpss_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_fixed_point_sigmoid_silu_core;

	localparam longint UNIT = fpss_pkg::ONE_SCALE;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_ITEMS = 400;
	localparam int LONG_HOLD = 80;
	localparam int TAIL_CYCLES = 30;

	typedef struct {
		logic signed [fpss_pkg::X_W-1:0] arg;
		logic [fpss_pkg::SIG_W-1:0]      sigmoid;
		logic signed [fpss_pkg::X_W-1:0] silu;
	} activation_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic x_valid = 1'b0;
	logic x_stall;
	logic signed [fpss_pkg::X_W-1:0] x_value = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [fpss_pkg::SIG_W-1:0] sigmoid_value;
	logic signed [fpss_pkg::X_W-1:0] silu_value;

	longint exp_points [16] = '{4096, 1507, 554, 204, 75, 28, 10, 4, 1, 0, 0, 0, 0, 0, 0, 0};
	int directed_args [25] = '{0, 1, -1, 2047, -2047, 2048, -2048, 4096, -4096, 4095,
		8*4096-1, 8*4096, -8*4096+1, -8*4096, -8*4096-1,
		9*4096-1, 9*4096, -9*4096+1, -9*4096,
		32'h7FFFFFFF, 32'h80000000, 32'h55555555, 32'hAAAAAAAA, 7*4096+4095, -3*4096-2048};

	logic signed [fpss_pkg::X_W-1:0] pending_args [$];
	activation_t expected_beats [$];
	int mismatch_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	logic [2:0] stall_phase = '0;

	fixed_point_sigmoid_silu_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.x_valid      (x_valid),
		.x_stall      (x_stall),
		.x_value      (x_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sigmoid_value(sigmoid_value),
		.silu_value   (silu_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint exp_falloff(longint a);
		longint n, f, lo, hi;
		if (a <= 0)
			return UNIT;
		if (a >= 8 * UNIT)
			return 0;
		n = a / UNIT;
		f = a - n * UNIT;
		lo = exp_points[n & 15];
		hi = exp_points[(n + 1) & 15];
		return lo + ((hi - lo) * f) / UNIT;
	endfunction

	function automatic longint sigmoid_fixed(longint x);
		longint e, d;
		if (x >= 9 * UNIT)
			return UNIT;
		if (x <= -9 * UNIT)
			return 0;
		if (x >= 0) begin
			e = exp_falloff(x);
			d = UNIT + e;
			return (UNIT * UNIT + d / 2) / d;
		end
		e = exp_falloff(-x);
		if (e == 0)
			return 0;
		d = e + UNIT;
		return (e * UNIT + d / 2) / d;
	endfunction

	function automatic activation_t predict_activation(logic signed [fpss_pkg::X_W-1:0] arg);
		longint x, s, q, r, silu;
		activation_t res;
		x = arg;
		s = sigmoid_fixed(x);
		q = x / UNIT;
		r = x - q * UNIT;
		silu = q * s + (r * s + UNIT / 2) / UNIT;
		res.arg = arg;
		res.sigmoid = s[fpss_pkg::SIG_W-1:0];
		res.silu = silu[fpss_pkg::X_W-1:0];
		return res;
	endfunction

	task automatic wait_drained();
		while (pending_args.size() != 0 || x_valid || expected_beats.size() != 0)
			@(negedge clk);
	endtask

	// sender: bursts of random length separated by random gaps
	always @(posedge clk) begin
		logic offer;
		offer = 1'b0;
		if (arst_n) begin
			if (x_valid && !x_stall)
				expected_beats.push_back(predict_activation(x_value));
			if (x_valid && x_stall) begin
				offer = 1'b1;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_args.size() != 0) begin
				offer = 1'b1;
				x_value <= pending_args.pop_front();
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(0, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			x_valid <= offer;
		end
	end

	// receiver: stall modes change over time; long holds on request or at random
	always @(posedge clk) begin
		logic stall_next;
		stall_next = 1'b0;
		if (arst_n) begin
			stall_phase <= stall_phase + 3'd1;
			if (hold_left > 0) begin
				stall_next = 1'b1;
				hold_left <= hold_left - 1;
			end else if (hold_served != hold_requests) begin
				stall_next = 1'b1;
				hold_served <= hold_requests;
				hold_left <= LONG_HOLD;
			end else if ($urandom_range(0, 499) == 0) begin
				stall_next = 1'b1;
				hold_left <= $urandom_range(10, 40);
			end else begin
				case (stall_mode)
					1: stall_next = ($urandom_range(0, 7) == 0);
					2: stall_next = ($urandom_range(0, 1) == 1);
					3: stall_next = (stall_phase < 3'd3);
					default: stall_next = 1'b0;
				endcase
			end
			if (mode_left == 0) begin
				mode_left <= $urandom_range(50, 300);
				stall_mode <= $urandom_range(0, 3);
			end else begin
				mode_left <= mode_left - 1;
			end
			result_stall <= stall_next;
		end
	end

	always @(posedge clk) begin
		activation_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_beats.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat: sigmoid %0d silu %0d",
						sigmoid_value, silu_value);
			end else begin
				want = expected_beats.pop_front();
				if (sigmoid_value !== want.sigmoid || silu_value !== want.silu) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch x=%0d: sigmoid exp %0d got %0d, silu exp %0d got %0d",
							want.arg, want.sigmoid, sigmoid_value, want.silu, silu_value);
				end
			end
		end
	end

	initial begin
		int arg;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_args[i])
			pending_args.push_back(directed_args[i]);
		wait_drained();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			// fill the pipeline against a held-off receiver
			if (phase == 1)
				hold_requests++;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				case ($urandom_range(0, 9))
					0, 1: arg = $urandom;
					2, 3, 4, 5: arg = int'($urandom_range(0, 20 * 4096)) - 10 * 4096;
					6: arg = (int'($urandom_range(0, 20)) - 10) * 4096
						+ int'($urandom_range(0, 6)) - 3;
					7: begin
						arg = $urandom_range(0, 4095);
						if ($urandom_range(0, 1))
							arg = -arg;
					end
					8: begin
						arg = $urandom;
						arg[30] = ~arg[31];
					end
					default: begin
						arg = 8 * 4096 + int'($urandom_range(0, 4096));
						if ($urandom_range(0, 1))
							arg = -arg;
					end
				endcase
				pending_args.push_back(arg);
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_beats.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== fixed_point_sigmoid_silu_core.f =====
rtl/fpss_pkg.sv
rtl/fixed_point_sigmoid_silu_core.sv
rtl/fpss_checker.sv
tb/tb_fixed_point_sigmoid_silu_core.sv
